FILE: design/pba_pkg.sv
// Shared types and constants of the page bitmap allocator.
package pba_pkg;

	// Fixed field widths.
	localparam int ADDR_W     = 48;
	localparam int LIMIT_W    = 17;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;

	// Request codes.
	localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

	// Register map and reset values.
	localparam logic [APB_ADDR_W-1:0] REG_PAGE_LIMIT = 2'd0;
	localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 17'd65536;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SUM_RD,
		S_SUM_CHK,
		S_WORD_RD,
		S_WORD_CHK,
		S_UPD_RD,
		S_UPD_WR
	} pba_state_t;

endpackage

FILE: design/pba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/pba_apb_regs.sv
// APB configuration register holding the page limit.
module pba_apb_regs
	import pba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [LIMIT_W-1:0]    page_limit
);

	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Page limit register; writes to other addresses are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit <= LIMIT_RESET;
		end else if (wr_en && paddr == REG_PAGE_LIMIT) begin
			page_limit <= pwdata[LIMIT_W-1:0];
		end
	end

	// Read mux.
	always_comb begin
		prdata = '0;
		if (paddr == REG_PAGE_LIMIT) begin
			prdata = APB_DATA_W'(page_limit);
		end
	end

endmodule

FILE: design/pba_lsb_find.sv
// Finds the index of the lowest set bit of a vector.
module pba_lsb_find #(
	parameter int W = 64,
	localparam int IW = (W > 1) ? $clog2(W) : 1
) (
	input  logic [W-1:0]  vec,
	output logic          found,
	output logic [IW-1:0] idx
);

	logic [W-1:0] iso;

	// Isolate the lowest set bit, then encode its position.
	assign iso   = vec & (~vec + W'(1));
	assign found = |vec;

	always_comb begin
		idx = '0;
		for (int i = 0; i < W; i++) begin
			if (iso[i]) begin
				idx = idx | IW'(i);
			end
		end
	end

endmodule

FILE: design/page_bitmap_allocator.sv
// Top level of the first-fit page bitmap allocator.
//
// Usage: a request is taken at a clock edge where start is high and busy is
// low; mode selects allocate, free or reserve, and address gives the byte
// address for free and reserve. Each request gives one result beat: done is
// high for exactly one cycle with page_address and status. The receiver
// cannot stall; the result simply appears, and a new request may be started
// in the cycle where done is high.
// Sequence: free and reserve read and write back one bitmap word, and end
// after the read alone when the page is out of range; the unused mode is
// answered straight from idle. An allocate reads summary words in turn,
// skipping those whose every covered word is full, then reads the first
// bitmap word with a free page; it ends without a grant when no page below
// the limit is free. The summary RAM, one bit per bitmap word marking words
// with a free page, steers that scan. After reset a clearing pass marks every
// page used, one bitmap word per cycle (1024 words at the defaults). busy is
// high during the pass; the page_limit register can be written over APB at
// any time the block is idle.
// WORD_BITS and PAGE_BYTES must be powers of two; the block does not check.
module page_bitmap_allocator
	import pba_pkg::*;
#(
	parameter int NUM_PAGES  = 65536,
	parameter int PAGE_BYTES = 4096,
	parameter int WORD_BITS  = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  start,
	output logic                  busy,
	input  logic [MODE_W-1:0]     mode,
	input  logic [ADDR_W-1:0]     address,
	output logic                  done,
	output logic [ADDR_W-1:0]     page_address,
	output logic [STATUS_W-1:0]   status
);

	localparam int WB        = WORD_BITS;
	localparam int BIT_W     = $clog2(WB);
	localparam int PB_SH     = $clog2(PAGE_BYTES);
	localparam int NUM_WORDS = (NUM_PAGES + WB - 1) / WB;
	localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int SUM_DEPTH = (NUM_WORDS + WB - 1) / WB;
	localparam int SIDX_W    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
	localparam int WW        = SIDX_W + BIT_W;
	localparam int PGW       = ADDR_W - PB_SH;
	localparam int NP_W      = $clog2(NUM_PAGES + 1);
	localparam int EW        = (NP_W > LIMIT_W) ? NP_W : LIMIT_W;
	localparam logic [WB-1:0] FULL = {WB{1'b1}};

	// Control state.
	pba_state_t state_q, state_d;
	logic [WIDX_W-1:0]   clr_q;
	logic [SIDX_W:0]     s_q;
	logic                done_q;

	// Request and result payload.
	logic [MODE_W-1:0]   mode_q;
	logic [PGW-1:0]      page_q;
	logic [WW-1:0]       w_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   page_address_q;

	// Configuration.
	logic [LIMIT_W-1:0]  page_limit;
	logic [EW-1:0]       lim_ext, lim_eff;

	// Memory ports.
	logic              bm_we, bm_re;
	logic [WIDX_W-1:0] bm_waddr, bm_raddr;
	logic [WB-1:0]     bm_wdata, bm_rdata;
	logic              sum_we, sum_re;
	logic [SIDX_W-1:0] sum_waddr, sum_raddr;
	logic [WB-1:0]     sum_wdata, sum_rdata;

	// Datapath.
	logic [ADDR_W-1:0] lim_cmp, page_cmp, sum_base, word_base;
	logic              page_oor, sum_end, word_oor;
	logic [EW-1:0]     rem;
	logic [WB-1:0]     valid_mask, free_bits;
	logic              sum_found, word_found;
	logic [BIT_W-1:0]  sum_idx, word_idx;
	logic [WW-1:0]     page_word, cur_word, clr_word;
	logic [BIT_W-1:0]  page_bit;
	logic [WB-1:0]     alloc_word, upd_word, new_word, sum_new;
	logic [WW+BIT_W-1:0] alloc_page;

	// Result beat from the sequencer.
	logic                res_fire;
	logic [STATUS_W-1:0] res_status;
	logic [ADDR_W-1:0]   res_addr;

	pba_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.page_limit (page_limit)
	);

	// Bitmap words, one used bit per page.
	pba_ram #(.WIDTH(WB), .DEPTH(NUM_WORDS)) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.re    (bm_re),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	// Summary words, one bit per bitmap word that still has a clear bit.
	pba_ram #(.WIDTH(WB), .DEPTH(SUM_DEPTH)) u_summary (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.re    (sum_re),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	pba_lsb_find #(.W(WB)) u_sum_find (
		.vec   (sum_rdata),
		.found (sum_found),
		.idx   (sum_idx)
	);

	pba_lsb_find #(.W(WB)) u_word_find (
		.vec   (free_bits),
		.found (word_found),
		.idx   (word_idx)
	);

	// Effective limit: a limit above the capacity acts as the capacity.
	assign lim_ext = EW'(page_limit);
	assign lim_eff = (lim_ext > EW'(NUM_PAGES)) ? EW'(NUM_PAGES) : lim_ext;
	assign lim_cmp = ADDR_W'(lim_eff);

	// Range checks for the request page and the scan positions.
	assign page_cmp  = ADDR_W'(page_q);
	assign sum_base  = ADDR_W'(s_q) << (2 * BIT_W);
	assign word_base = ADDR_W'(w_q) << BIT_W;
	assign page_oor  = page_cmp >= lim_cmp;
	assign sum_end   = (s_q == (SIDX_W + 1)'(SUM_DEPTH)) || (sum_base >= lim_cmp);
	assign word_oor  = word_base >= lim_cmp;

	// Only bits of pages below the limit may be picked in the last word.
	assign rem        = EW'(lim_cmp - word_base);
	assign valid_mask = (rem >= EW'(WB)) ? FULL : ~(FULL << rem[BIT_W-1:0]);
	assign free_bits  = ~bm_rdata & valid_mask;

	// New word contents and the matching summary bit.
	assign page_word  = page_q[WW+BIT_W-1:BIT_W];
	assign page_bit   = page_q[BIT_W-1:0];
	assign alloc_word = bm_rdata | (WB'(1) << word_idx);
	assign upd_word   = (mode_q == MODE_RESERVE) ? (bm_rdata | (WB'(1) << page_bit))
		: (bm_rdata & ~(WB'(1) << page_bit));
	assign cur_word   = (mode_q == MODE_ALLOC) ? w_q : page_word;
	assign new_word   = (mode_q == MODE_ALLOC) ? alloc_word : upd_word;
	assign clr_word   = WW'(clr_q);
	assign alloc_page = {w_q, word_idx};

	always_comb begin
		sum_new = sum_rdata;
		sum_new[cur_word[BIT_W-1:0]] = (new_word != FULL);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (clr_q == WIDX_W'(NUM_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (mode) inside
						MODE_ALLOC: state_d = S_SUM_RD;
						MODE_FREE, MODE_RESERVE: state_d = S_UPD_RD;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SUM_RD:   state_d = sum_end ? S_IDLE : S_SUM_CHK;
			S_SUM_CHK:  state_d = sum_found ? S_WORD_RD : S_SUM_RD;
			S_WORD_RD:  state_d = word_oor ? S_IDLE : S_WORD_CHK;
			S_WORD_CHK: state_d = S_IDLE;
			S_UPD_RD:   state_d = page_oor ? S_IDLE : S_UPD_WR;
			S_UPD_WR:   state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Memory controls and result beat.
	always_comb begin
		bm_we      = 1'b0;
		bm_waddr   = cur_word[WIDX_W-1:0];
		bm_wdata   = new_word;
		bm_re      = 1'b0;
		bm_raddr   = cur_word[WIDX_W-1:0];
		sum_we     = 1'b0;
		sum_waddr  = cur_word[WW-1:BIT_W];
		sum_wdata  = sum_new;
		sum_re     = 1'b0;
		sum_raddr  = cur_word[WW-1:BIT_W];
		res_fire   = 1'b0;
		res_status = STAT_DONE;
		res_addr   = '0;
		unique case (state_q)
			S_INIT: begin
				bm_we     = 1'b1;
				bm_waddr  = clr_q;
				bm_wdata  = FULL;
				sum_we    = 1'b1;
				sum_waddr = clr_word[WW-1:BIT_W];
				sum_wdata = '0;
			end
			S_IDLE: begin
				if (start && mode != MODE_ALLOC && mode != MODE_FREE
						&& mode != MODE_RESERVE) begin
					res_fire = 1'b1;
				end
			end
			S_SUM_RD: begin
				sum_re    = !sum_end;
				sum_raddr = s_q[SIDX_W-1:0];
				if (sum_end) begin
					res_fire   = 1'b1;
					res_status = STAT_NO_FREE;
				end
			end
			S_SUM_CHK: begin
			end
			S_WORD_RD: begin
				bm_re = !word_oor;
				if (word_oor) begin
					res_fire   = 1'b1;
					res_status = STAT_NO_FREE;
				end
			end
			S_WORD_CHK: begin
				res_fire = 1'b1;
				if (word_found) begin
					bm_we    = 1'b1;
					sum_we   = 1'b1;
					res_addr = ADDR_W'(alloc_page) << PB_SH;
				end else begin
					res_status = STAT_NO_FREE;
				end
			end
			S_UPD_RD: begin
				bm_re  = !page_oor;
				sum_re = !page_oor;
				if (page_oor) begin
					res_fire   = 1'b1;
					res_status = STAT_RANGE;
				end
			end
			S_UPD_WR: begin
				bm_we    = 1'b1;
				sum_we   = 1'b1;
				res_fire = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			clr_q   <= '0;
			s_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_fire;
			if (state_q == S_INIT) begin
				clr_q <= clr_q + WIDX_W'(1);
			end
			if (state_q == S_IDLE) begin
				s_q <= '0;
			end else if (state_q == S_SUM_CHK && !sum_found) begin
				s_q <= s_q + (SIDX_W + 1)'(1);
			end
		end
	end

	// Request capture, scan word and result registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q <= mode;
			page_q <= address[ADDR_W-1:PB_SH];
		end
		if (state_q == S_SUM_CHK) begin
			w_q <= {s_q[SIDX_W-1:0], sum_idx};
		end
		if (res_fire) begin
			status_q       <= res_status;
			page_address_q <= res_addr;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign page_address = page_address_q;

	// A result beat always follows a busy cycle or a request offered while idle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result beat without a preceding request");

	// Only a successful allocate returns a nonzero page address.
	a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_DONE) |-> (page_address == '0))
		else $error("nonzero page address on a failed request");

	// An allocate write sets exactly one new bit in the word.
	a_alloc_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WORD_CHK && bm_we)
			|-> ($countones(bm_wdata) == $countones(bm_rdata) + 1))
		else $error("allocate changed other than one bit");

	// Every bitmap update keeps the summary bit in step with the word.
	a_summary_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(bm_we && state_q != S_INIT)
			|-> (sum_we && (sum_wdata[cur_word[BIT_W-1:0]] == (bm_wdata != FULL))))
		else $error("summary bit out of step with bitmap word");

endmodule

FILE: dv/page_bitmap_allocator_tb.sv
// Self-checking testbench for the first-fit page bitmap allocator.
module page_bitmap_allocator_tb
	import pba_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PAGES    = 65536;
	localparam int PAGE_BYTES   = 4096;
	localparam int WORD_BITS    = 64;
	localparam int NUM_WORDS    = NUM_PAGES / WORD_BITS;
	localparam int PAGE_SHIFT   = 12;
	localparam int SETTLE_BEATS = 40;
	localparam int PHASE_ITEMS  = 240;
	localparam int MAX_PRINTED  = 40;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ADDR_W-1:0] address;
	} page_request_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   page_address;
		logic [STATUS_W-1:0] status;
	} page_reply_t;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  start   = 1'b0;
	logic                  busy;
	logic [MODE_W-1:0]     mode    = '0;
	logic [ADDR_W-1:0]     address = '0;
	logic                  done;
	logic [ADDR_W-1:0]     page_address;
	logic [STATUS_W-1:0]   status;

	// Shadow copy of the bitmap and the page limit register.
	bit [WORD_BITS-1:0]   used_words [0:NUM_WORDS-1];
	logic [LIMIT_W-1:0]   limit_shadow;

	page_request_t request_queue[$];
	page_reply_t   predicted_replies[$];
	page_request_t drive_req;
	page_reply_t   oldest_reply;

	int unsigned idle_pct       = 0;
	int unsigned error_count    = 0;
	int unsigned accepted_count = 0;
	int unsigned granted_count  = 0;
	int unsigned no_free_count  = 0;
	int unsigned range_count    = 0;
	int unsigned limit_writes   = 0;

	page_bitmap_allocator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.address     (address),
		.done        (done),
		.page_address(page_address),
		.status      (status)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_PRINTED) begin
			$display("ERROR at %0t ns: %s", $time, what);
		end
	endtask

	// Works out the reply to one request and updates the shadow bitmap.
	function automatic page_reply_t predict_request(input logic [MODE_W-1:0] req_mode,
							input logic [ADDR_W-1:0] req_addr);
		page_reply_t      reply;
		int unsigned      lim;
		logic [35:0]      page;
		bit               found;
		reply.page_address = '0;
		reply.status = STAT_DONE;
		found = 1'b0;
		lim = (limit_shadow > NUM_PAGES) ? NUM_PAGES : limit_shadow;
		case (req_mode) inside
			MODE_ALLOC: begin
				reply.status = STAT_NO_FREE;
				// First fit: lowest clear bit below the limit, skipping full words.
				for (int w = 0; w < NUM_WORDS && w * WORD_BITS < lim && !found; w++) begin
					if (used_words[w] != '1) begin
						for (int b = 0; b < WORD_BITS && !found; b++) begin
							if (w * WORD_BITS + b < lim && !used_words[w][b]) begin
								used_words[w][b] = 1'b1;
								reply.page_address = ADDR_W'((w * WORD_BITS + b) * PAGE_BYTES);
								reply.status = STAT_DONE;
								found = 1'b1;
							end
						end
					end
				end
			end
			MODE_FREE, MODE_RESERVE: begin
				page = req_addr[ADDR_W-1:PAGE_SHIFT];
				if (page >= lim) begin
					reply.status = STAT_RANGE;
				end else begin
					used_words[page[15:6]][page[5:0]] = (req_mode == MODE_RESERVE);
				end
			end
			default: begin
			end
		endcase
		return reply;
	endfunction

	// Request driver: offers the next queued request, holds it while busy.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predicted_replies.push_back(predict_request(mode, address));
				accepted_count++;
			end
			if (!start || !busy) begin
				if (request_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
					drive_req = request_queue.pop_front();
					start <= 1'b1;
					mode <= drive_req.mode;
					address <= drive_req.address;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Result monitor: every done beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (predicted_replies.size() == 0) begin
				report_mismatch("result beat with no request pending");
			end else begin
				oldest_reply = predicted_replies.pop_front();
				if (page_address !== oldest_reply.page_address) begin
					report_mismatch($sformatf("page_address %h, expected %h",
						page_address, oldest_reply.page_address));
				end
				if (status !== oldest_reply.status) begin
					report_mismatch($sformatf("status %0d, expected %0d",
						status, oldest_reply.status));
				end
				case (oldest_reply.status)
					STAT_NO_FREE: no_free_count++;
					STAT_RANGE:   range_count++;
					default:      granted_count++;
				endcase
			end
		end
	end

	task automatic queue_request(input logic [MODE_W-1:0] req_mode,
				     input logic [ADDR_W-1:0] req_addr);
		page_request_t req;
		req.mode = req_mode;
		req.address = req_addr;
		request_queue.push_back(req);
	endtask

	// Waits until every queued request has been taken and answered.
	task automatic wait_idle();
		@(posedge clk);
		while (request_queue.size() > 0 || start || predicted_replies.size() > 0 || busy) begin
			@(posedge clk);
		end
		repeat (SETTLE_BEATS) @(posedge clk);
	endtask

	// APB write of the page limit, then a read back of the same register.
	task automatic set_page_limit(input logic [LIMIT_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_PAGE_LIMIT;
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		limit_shadow = value;
		limit_writes++;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== APB_DATA_W'(value)) begin
			report_mismatch($sformatf("page_limit reads %h, expected %h", prdata, value));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random request shaped around the current limit: mostly in-range frees,
	// reserves and allocations, with a little out-of-range and unused-mode noise.
	function automatic page_request_t random_request();
		page_request_t req;
		int unsigned   eff;
		int unsigned   pick;
		int unsigned   page;
		int            low;
		eff = (limit_shadow > NUM_PAGES) ? NUM_PAGES : limit_shadow;
		pick = $urandom_range(0, 99);
		req.address = {16'($urandom), 32'($urandom)};
		if (pick < 40) begin
			req.mode = MODE_ALLOC;
		end else if (pick < 93) begin
			req.mode = (pick < 78) ? MODE_FREE : MODE_RESERVE;
			if (pick >= 88) begin
				// Either a wide random address or a page just past the limit.
				if ($urandom_range(0, 1) == 0) begin
					page = eff + $urandom_range(0, 3);
					req.address = {(ADDR_W - PAGE_SHIFT)'(page), 12'($urandom)};
				end
			end else begin
				if (eff == 0) begin
					page = $urandom_range(0, 7);
				end else begin
					case ($urandom_range(0, 3))
						0: begin
							low = int'(eff) - 70;
							page = $urandom_range(eff - 1, (low < 0) ? 0 : low);
						end
						1:       page = $urandom_range(((eff < 200) ? eff : 200) - 1, 0);
						default: page = $urandom_range(eff - 1, 0);
					endcase
				end
				req.address = ADDR_W'({page, 12'($urandom)});
			end
		end else begin
			req.mode = MODE_UNUSED;
		end
		return req;
	endfunction

	// Stimulus sequence.
	initial begin
		int unsigned phase_limit [8];
		for (int w = 0; w < NUM_WORDS; w++) used_words[w] = '1;
		limit_shadow = LIMIT_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 25;

		// Reset limit: fully used bitmap, top page, address edges, unused mode.
		queue_request(MODE_ALLOC, 48'h0);
		queue_request(MODE_FREE, 48'h0);
		queue_request(MODE_FREE, 48'h0000_0FFF_FFFF);
		queue_request(MODE_FREE, 48'h0000_1000_0000);
		queue_request(MODE_RESERVE, '1);
		queue_request(MODE_UNUSED, '1);
		queue_request(MODE_ALLOC, '1);
		queue_request(MODE_ALLOC, 48'h0);
		queue_request(MODE_ALLOC, 48'h0);
		queue_request(MODE_FREE, 48'h5123);
		queue_request(MODE_FREE, 48'h5FFF);
		queue_request(MODE_RESERVE, 48'h5000);
		queue_request(MODE_FREE, 48'h46000);
		queue_request(MODE_FREE, 48'h40000);
		queue_request(MODE_ALLOC, 48'h0);
		wait_idle();

		// Zero limit: nothing can be allocated, freed or reserved.
		set_page_limit('0);
		queue_request(MODE_ALLOC, 48'h0);
		queue_request(MODE_FREE, 48'h0);
		queue_request(MODE_RESERVE, 48'h0);
		wait_idle();

		// Largest register value acts as the full capacity.
		set_page_limit('1);
		queue_request(MODE_FREE, 48'h0FFF_F000);
		queue_request(MODE_ALLOC, 48'h0);
		queue_request(MODE_ALLOC, 48'h0);
		queue_request(MODE_FREE, 48'h64000);
		wait_idle();

		// A free page above a lowered limit must never be handed out.
		set_page_limit(17'd65);
		queue_request(MODE_ALLOC, 48'h0);
		queue_request(MODE_RESERVE, 48'h40000);
		queue_request(MODE_FREE, 48'h41000);
		wait_idle();

		// Random phases, each under its own limit, with the idle rate set per group of phases.
		phase_limit = '{65536, 1, 64, 1000, 0, 65535, 100000, 4097};
		phase_limit[4] = $urandom_range(65536, 2);
		for (int p = 0; p < 8; p++) begin
			set_page_limit(LIMIT_W'(phase_limit[p]));
			idle_pct = (p < 3) ? 25 : ((p < 6) ? 68 : 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				request_queue.push_back(random_request());
			end
			wait_idle();
		end

		if (predicted_replies.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", predicted_replies.size()));
		end
		$display("Covered %0d requests under %0d page limit settings:", accepted_count,
			limit_writes);
		$display("%0d successful replies, %0d with no free page, %0d out of range.",
			granted_count, no_free_count, range_count);
		if (error_count == 0) begin
			$display("PASS page_bitmap_allocator");
		end else begin
			$display("FAIL page_bitmap_allocator");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#20_000_000;
		$display("FAIL page_bitmap_allocator");
		$finish;
	end

endmodule
